// File: rtl/core/greedy_contiguous_partitioner_unit_assert.svh
// Assertion macros for the greedy contiguous partitioner checker.
// The macros expect signals named clock and reset in the scope where they are used.
`ifndef GREEDY_CONTIGUOUS_PARTITIONER_UNIT_ASSERT_SVH
`define GREEDY_CONTIGUOUS_PARTITIONER_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset
`define GCP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define GCP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// State in the cycle after a reset edge
`define GCP_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/gcp_pkg.sv
// Shared types, widths and helper functions for the greedy contiguous partitioner.
// No dependencies; used by gcp_csr, gcp_ctrl, gcp_dpath and the top module.
`default_nettype none

package gcp_pkg;

   // Clamp limits on the part and leaf counts
   localparam int MAX_PARTS  = 1024;
   localparam int MAX_LEAVES = 65536;

   // Register and field widths
   localparam int PARTS_W  = 11;
   localparam int LEAVES_W = 17;
   localparam int WEIGHT_W = 16;
   localparam int TOTAL_W  = 48;
   localparam int TALLY_W  = 24;
   localparam int PART_W   = 10;

   // Datapath widths
   localparam int LEAF_PROD_W = WEIGHT_W + TALLY_W;          // one weighted tally
   localparam int RUN_W       = 57;                          // running cost over a pass
   localparam int SCALE_W     = PARTS_W + LEAVES_W;          // raw P*L products
   localparam int FACTOR_W    = 28;                          // 2*P*L and 2*(i+1)*L+P
   localparam int C_LO_W      = 29;
   localparam int C_HI_W      = RUN_W - C_LO_W;
   localparam int T_LO_W      = TOTAL_W / 2;
   localparam int T_HI_W      = TOTAL_W - T_LO_W;
   localparam int PP0_W       = C_LO_W + FACTOR_W;
   localparam int PP1_W       = C_HI_W + FACTOR_W;
   localparam int PP2_W       = T_LO_W + FACTOR_W;
   localparam int PP3_W       = T_HI_W + FACTOR_W;
   localparam int LHS_W       = RUN_W + FACTOR_W;
   localparam int RHS_W       = TOTAL_W + FACTOR_W;

   // Stream and register port widths
   localparam int REQ_DATA_W = 2 * TALLY_W;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_LO = 3;

   typedef enum logic [2:0] {
      CSR_NUM_PARTS   = 3'd0,
      CSR_NUM_LEAVES  = 3'd1,
      CSR_WORK_WEIGHT = 3'd2,
      CSR_LOAD_WEIGHT = 3'd3,
      CSR_TOTAL_COST  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PARTS_W-1:0]  num_parts;
      logic [LEAVES_W-1:0] num_leaves;
      logic [WEIGHT_W-1:0] work_weight;
      logic [WEIGHT_W-1:0] load_weight;
      logic [TOTAL_W-1:0]  total_cost;
   } cfg_type;

   // Controller to datapath: one strobe per step of the sequence
   typedef struct packed {
      logic load;
      logic mul_cost;
      logic sum;
      logic mul_test;
      logic add_test;
      logic decide;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_busy;
   } dp_status_type;

   function automatic logic [PARTS_W-1:0] clamp_parts(input logic [PARTS_W-1:0] value);
      logic [PARTS_W-1:0] result;
      result = value;
      if (value == '0)
         result = PARTS_W'(1);
      else if (value > PARTS_W'(MAX_PARTS))
         result = PARTS_W'(MAX_PARTS);
      return result;
   endfunction

   function automatic logic [LEAVES_W-1:0] clamp_leaves(input logic [LEAVES_W-1:0] value);
      logic [LEAVES_W-1:0] result;
      result = value;
      if (value == '0)
         result = LEAVES_W'(1);
      else if (value > LEAVES_W'(MAX_LEAVES))
         result = LEAVES_W'(MAX_LEAVES);
      return result;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/gcp_csr.sv
// Configuration register file of the partitioner, APB-style access.
// Depends on gcp_pkg for widths, register indexes and the cfg_type bundle.
`default_nettype none

module gcp_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [gcp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [gcp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [gcp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready,
   output gcp_pkg::cfg_type                   cfg
);
   import gcp_pkg::*;

   logic [PARTS_W-1:0]  num_parts_ff,   num_parts_in;
   logic [LEAVES_W-1:0] num_leaves_ff,  num_leaves_in;
   logic [WEIGHT_W-1:0] work_weight_ff, work_weight_in;
   logic [WEIGHT_W-1:0] load_weight_ff, load_weight_in;
   logic [TOTAL_W-1:0]  total_cost_ff,  total_cost_in;
   logic                wr_en;
   csr_index_type       index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:CSR_IDX_LO]);

   // Write decode; writes beyond the register list are dropped
   always_comb begin
      num_parts_in   = num_parts_ff;
      num_leaves_in  = num_leaves_ff;
      work_weight_in = work_weight_ff;
      load_weight_in = load_weight_ff;
      total_cost_in  = total_cost_ff;
      if (wr_en) begin
         unique case (index)
            CSR_NUM_PARTS:   num_parts_in   = csr_pwdata[PARTS_W-1:0];
            CSR_NUM_LEAVES:  num_leaves_in  = csr_pwdata[LEAVES_W-1:0];
            CSR_WORK_WEIGHT: work_weight_in = csr_pwdata[WEIGHT_W-1:0];
            CSR_LOAD_WEIGHT: load_weight_in = csr_pwdata[WEIGHT_W-1:0];
            CSR_TOTAL_COST:  total_cost_in  = csr_pwdata[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_parts_ff   <= PARTS_W'(1);
         num_leaves_ff  <= LEAVES_W'(1);
         work_weight_ff <= WEIGHT_W'(1);
         load_weight_ff <= WEIGHT_W'(1);
         total_cost_ff  <= TOTAL_W'(1);
      end else begin
         num_parts_ff   <= num_parts_in;
         num_leaves_ff  <= num_leaves_in;
         work_weight_ff <= work_weight_in;
         load_weight_ff <= load_weight_in;
         total_cost_ff  <= total_cost_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (index)
         CSR_NUM_PARTS:   csr_prdata = CSR_DATA_W'(num_parts_ff);
         CSR_NUM_LEAVES:  csr_prdata = CSR_DATA_W'(num_leaves_ff);
         CSR_WORK_WEIGHT: csr_prdata = CSR_DATA_W'(work_weight_ff);
         CSR_LOAD_WEIGHT: csr_prdata = CSR_DATA_W'(load_weight_ff);
         CSR_TOTAL_COST:  csr_prdata = CSR_DATA_W'(total_cost_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.num_parts   = num_parts_ff;
   assign cfg.num_leaves  = num_leaves_ff;
   assign cfg.work_weight = work_weight_ff;
   assign cfg.load_weight = load_weight_ff;
   assign cfg.total_cost  = total_cost_ff;

endmodule

`default_nettype wire

// File: rtl/core/gcp_ctrl.sv
// Sequencing controller of the partitioner: steps one leaf through the datapath.
// Depends on gcp_pkg for the command and status bundles.
`default_nettype none

module gcp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output gcp_pkg::dp_cmd_type         cmd,
   input  wire gcp_pkg::dp_status_type status
);
   import gcp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_COST,
      ST_SUM,
      ST_MUL_TEST,
      ST_ADD_TEST,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and step strobes
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_COST;
            end
         end
         ST_MUL_COST: begin
            cmd.mul_cost = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_MUL_TEST;
         end
         ST_MUL_TEST: begin
            cmd.mul_test = 1'b1;
            state_in     = ST_ADD_TEST;
         end
         ST_ADD_TEST: begin
            cmd.add_test = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.decide = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/gcp_dpath.sv
// Datapath of the partitioner: leaf cost, split products of the share test,
// pass state and the result register. Depends on gcp_pkg.
`default_nettype none

module gcp_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gcp_pkg::cfg_type                cfg,
   input  wire gcp_pkg::dp_cmd_type             cmd,
   output gcp_pkg::dp_status_type               status,
   input  wire logic [gcp_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [gcp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser
);
   import gcp_pkg::*;

   // Operand and intermediate registers (payload, no reset)
   logic [TALLY_W-1:0]     work_ff, count_ff;
   logic [LEAF_PROD_W-1:0] prod_w_ff, prod_l_ff;
   logic [SCALE_W-2:0]     pl_ff, ql_ff;
   logic [RUN_W-1:0]       c_ff;
   logic [FACTOR_W-1:0]    k1_ff, k2_ff;
   logic [PP0_W-1:0]       pp0_ff;
   logic [PP1_W-1:0]       pp1_ff;
   logic [PP2_W-1:0]       pp2_ff;
   logic [PP3_W-1:0]       pp3_ff;
   logic [LHS_W-1:0]       lhs_ff;
   logic [RHS_W-1:0]       rhs_ff;
   logic [PART_W-1:0]      part_idx_ff;
   logic                   last_ff, err_ff;

   // Pass state
   logic [RUN_W-1:0]    running_cost_ff, running_cost_in;
   logic [PART_W-1:0]   current_part_ff, current_part_in;
   logic [LEAVES_W-1:0] leaf_position_ff, leaf_position_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [PARTS_W-1:0]  p_clamp;
   logic [LEAVES_W-1:0] l_clamp;
   logic [PARTS_W-1:0]  part_plus1;
   logic [SCALE_W-1:0]  pl_full, ql_full;

   logic                beyond, last_part, room, fits, is_last, join_part;
   logic [PARTS_W-1:0]  parts_left;
   logic [LEAVES_W:0]   remain;
   logic [PART_W-1:0]   next_part;
   logic [PART_W-1:0]   out_part;

   assign p_clamp    = clamp_parts(cfg.num_parts);
   assign l_clamp    = clamp_leaves(cfg.num_leaves);
   assign part_plus1 = {1'b0, current_part_ff} + PARTS_W'(1);

   // Normalising products for both sides of the share test
   assign pl_full = SCALE_W'(p_clamp) * SCALE_W'(l_clamp);
   assign ql_full = SCALE_W'(part_plus1) * SCALE_W'(l_clamp);

   // Arithmetic steps
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         work_ff  <= req_tdata[TALLY_W-1:0];
         count_ff <= req_tdata[REQ_DATA_W-1:TALLY_W];
      end
      if (cmd.mul_cost) begin
         prod_w_ff <= LEAF_PROD_W'(cfg.work_weight) * LEAF_PROD_W'(work_ff);
         prod_l_ff <= LEAF_PROD_W'(cfg.load_weight) * LEAF_PROD_W'(count_ff);
         pl_ff     <= pl_full[SCALE_W-2:0];
         ql_ff     <= ql_full[SCALE_W-2:0];
      end
      if (cmd.sum) begin
         c_ff  <= running_cost_ff + RUN_W'(prod_w_ff) + RUN_W'(prod_l_ff);
         k1_ff <= {pl_ff, 1'b0};
         k2_ff <= {ql_ff, 1'b0} + FACTOR_W'(p_clamp);
      end
      // partial products: 2*C*P*L and T*(2*(i+1)*L + P)
      if (cmd.mul_test) begin
         pp0_ff <= PP0_W'(c_ff[C_LO_W-1:0]) * PP0_W'(k1_ff);
         pp1_ff <= PP1_W'(c_ff[RUN_W-1:C_LO_W]) * PP1_W'(k1_ff);
         pp2_ff <= PP2_W'(cfg.total_cost[T_LO_W-1:0]) * PP2_W'(k2_ff);
         pp3_ff <= PP3_W'(cfg.total_cost[TOTAL_W-1:T_LO_W]) * PP3_W'(k2_ff);
      end
      if (cmd.add_test) begin
         lhs_ff <= LHS_W'(pp0_ff) + (LHS_W'(pp1_ff) << C_LO_W);
         rhs_ff <= RHS_W'(pp2_ff) + (RHS_W'(pp3_ff) << T_LO_W);
      end
      if (cmd.decide) begin
         part_idx_ff <= out_part;
         last_ff     <= beyond | is_last;
         err_ff      <= beyond | (LEAVES_W'(p_clamp) > l_clamp);
      end
   end

   // Placement decision for the current leaf
   always_comb begin
      beyond     = (leaf_position_ff >= l_clamp);
      last_part  = (part_plus1 >= p_clamp);
      parts_left = ({1'b0, current_part_ff} < p_clamp) ?
                   (p_clamp - {1'b0, current_part_ff}) : PARTS_W'(1);
      remain     = {1'b0, l_clamp} - {1'b0, leaf_position_ff} + (LEAVES_W+1)'(1);
      room       = (remain > (LEAVES_W+1)'(parts_left));
      fits       = last_part | (lhs_ff < LHS_W'(rhs_ff));
      join_part  = (leaf_position_ff == '0) | (fits & room);
      next_part  = join_part ? current_part_ff : (current_part_ff + PART_W'(1));
      is_last    = ({1'b0, leaf_position_ff} + (LEAVES_W+1)'(1)) == {1'b0, l_clamp};
      out_part   = beyond ? current_part_ff : next_part;
   end

   // Pass state update; a finished or overrun pass returns to zero
   always_comb begin
      running_cost_in  = running_cost_ff;
      current_part_in  = current_part_ff;
      leaf_position_in = leaf_position_ff;
      if (cmd.decide) begin
         if (beyond || is_last) begin
            running_cost_in  = '0;
            current_part_in  = '0;
            leaf_position_in = '0;
         end else begin
            running_cost_in  = c_ff;
            current_part_in  = next_part;
            leaf_position_in = leaf_position_ff + LEAVES_W'(1);
         end
      end
   end

   // Output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.decide)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_cost_ff  <= '0;
         current_part_ff  <= '0;
         leaf_position_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         running_cost_ff  <= running_cost_in;
         current_part_ff  <= current_part_in;
         leaf_position_ff <= leaf_position_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign status.out_busy = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = RSP_DATA_W'(part_idx_ff);
   assign rsp_tlast       = last_ff;
   assign rsp_tuser       = err_ff;

endmodule

`default_nettype wire

// File: rtl/core/greedy_contiguous_partitioner_unit.sv
// Greedy contiguous partitioner. Leaves stream in over the req_ channel in order,
// each carrying a work tally and a particle count; for every leaf one transfer on
// the rsp_ channel returns the part it is assigned to, with tlast on the final
// leaf of a pass and tuser flagging an overrun leaf or more parts than leaves.
// One leaf is in the datapath at a time: after acceptance it passes through the
// steps (leaf cost multiply, running sum, split 57x28 and 48x28 partial products,
// their 85-bit and 76-bit sums, then the compare and state update) and tready
// returns in the cycle after the final step, which can wait on rsp_. The output
// register lets the next leaf start while a result waits; the final step waits
// only when a previous result is still untaken. Registers sit at byte address
// 8*i: num_parts, num_leaves, work_weight, load_weight, total_cost; write them
// only while the block is idle.
// Depends on gcp_pkg, gcp_csr, gcp_ctrl and gcp_dpath.
`default_nettype none

module greedy_contiguous_partitioner_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // leaf input: [23:0] leaf_work, [47:24] leaf_count
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [gcp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // result: tdata [9:0] part_index, [15:10] zero; tlast last_leaf; tuser [0] error_flag
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [gcp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser,
   // configuration port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [gcp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [gcp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [gcp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import gcp_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Register file
   gcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer
   gcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Arithmetic and pass state
   gcp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: rtl/core/gcp_checker.sv
// Port-level checks on the partitioner and the bind that attaches them.
// Depends on greedy_contiguous_partitioner_unit_assert.svh.
`default_nettype none

`include "greedy_contiguous_partitioner_unit_assert.svh"

module gcp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   logic        req_xfer;
   logic        rsp_stall;
   logic [17:0] rsp_payload;

   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_payload = {rsp_tdata, rsp_tlast, rsp_tuser};

   // After a transfer the input stays closed while the leaf is in the datapath
   `GCP_ASSERT_NXT(a_busy_after_accept, req_xfer, !req_tready [*5], "input taken mid-leaf")

   // A stalled result holds
   `GCP_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_payload), "result changed")

   // A fresh result only comes out of the busy sequence
   `GCP_ASSERT_IMP(a_rsp_from_work, $rose(rsp_tvalid), $past(!req_tready), "result without leaf")

   // Reset leaves the block empty and ready
   `GCP_ASSERT_RST(a_reset_empty, !rsp_tvalid && req_tready, "block not empty after reset")

endmodule

bind greedy_contiguous_partitioner_unit gcp_checker u_gcp_checker (.*);

`default_nettype wire
